/* hdl/vfao_pkg.sv */
// ----------------------------------------------------------------------------
// vfao_pkg
// Types, constants and lookup functions shared by the voxel face AO mesher.
// ----------------------------------------------------------------------------
package vfao_pkg;

  localparam int CHUNK_EDGE_DEF = 16;
  localparam int QUEUE_DEPTH    = 4;
  localparam int NUM_FACES      = 6;
  localparam int AO_W           = 7;
  localparam int MASK_W         = 27;

  localparam logic [2:0] FACE_UP  = 3'd0;
  localparam logic [2:0] FACE_DN  = 3'd1;
  localparam logic [2:0] FACE_NZ  = 3'd2;
  localparam logic [2:0] FACE_PZ  = 3'd3;
  localparam logic [2:0] FACE_PX  = 3'd4;
  localparam logic [2:0] FACE_NX  = 3'd5;

  // neighbour bit of the direct neighbour of each face
  localparam logic [4:0] BIT_UP = 5'd16;
  localparam logic [4:0] BIT_DN = 5'd10;
  localparam logic [4:0] BIT_NZ = 5'd12;
  localparam logic [4:0] BIT_PZ = 5'd14;
  localparam logic [4:0] BIT_PX = 5'd22;
  localparam logic [4:0] BIT_NX = 5'd4;

  typedef struct packed {
    logic [3:0]        pos_x;
    logic [3:0]        pos_y;
    logic [3:0]        pos_z;
    logic [7:0]        block_id;
    logic [MASK_W-1:0] neighbour_solid;
  } in_t;

  typedef struct packed {
    logic [2:0] face;
    logic [3:0] out_x;
    logic [3:0] out_y;
    logic [3:0] out_z;
    logic [7:0] out_id;
    logic [7:0] ao_v0;
    logic [7:0] ao_v1;
    logic [7:0] ao_v2;
    logic [7:0] ao_v3;
    logic       flip_quad;
    logic       last_face;
  } out_t;

  typedef struct packed {
    logic [3:0]           x;
    logic [3:0]           y;
    logic [3:0]           z;
    logic [7:0]           id;
    logic [MASK_W-1:0]    mask;
    logic [NUM_FACES-1:0] open_faces;
  } entry_t;

  // {side, side2, corner} neighbour bits for a face and vertex
  function automatic logic [14:0] ao_taps(input logic [2:0] face, input logic [1:0] vert);
    logic [14:0] t;
    t = '0;
    unique case ({face, vert})
      {FACE_UP, 2'd0}: t = {5'd15, 5'd25, 5'd24};
      {FACE_UP, 2'd1}: t = {5'd25, 5'd17, 5'd26};
      {FACE_UP, 2'd2}: t = {5'd17, 5'd7,  5'd8};
      {FACE_UP, 2'd3}: t = {5'd15, 5'd7,  5'd6};
      {FACE_DN, 2'd0}: t = {5'd11, 5'd19, 5'd20};
      {FACE_DN, 2'd1}: t = {5'd19, 5'd9,  5'd18};
      {FACE_DN, 2'd2}: t = {5'd9,  5'd1,  5'd0};
      {FACE_DN, 2'd3}: t = {5'd11, 5'd1,  5'd2};
      {FACE_NZ, 2'd0}: t = {5'd15, 5'd3,  5'd6};
      {FACE_NZ, 2'd1}: t = {5'd3,  5'd9,  5'd0};
      {FACE_NZ, 2'd2}: t = {5'd9,  5'd21, 5'd18};
      {FACE_NZ, 2'd3}: t = {5'd15, 5'd21, 5'd24};
      {FACE_PZ, 2'd0}: t = {5'd17, 5'd23, 5'd26};
      {FACE_PZ, 2'd1}: t = {5'd23, 5'd11, 5'd20};
      {FACE_PZ, 2'd2}: t = {5'd11, 5'd5,  5'd2};
      {FACE_PZ, 2'd3}: t = {5'd17, 5'd5,  5'd8};
      {FACE_PX, 2'd0}: t = {5'd25, 5'd21, 5'd24};
      {FACE_PX, 2'd1}: t = {5'd21, 5'd19, 5'd18};
      {FACE_PX, 2'd2}: t = {5'd23, 5'd19, 5'd20};
      {FACE_PX, 2'd3}: t = {5'd23, 5'd25, 5'd26};
      {FACE_NX, 2'd0}: t = {5'd7,  5'd5,  5'd8};
      {FACE_NX, 2'd1}: t = {5'd5,  5'd1,  5'd2};
      {FACE_NX, 2'd2}: t = {5'd3,  5'd1,  5'd0};
      {FACE_NX, 2'd3}: t = {5'd3,  5'd7,  5'd6};
      default:         t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [7:0] ao_value(input logic [MASK_W-1:0] mask,
                                          input logic [14:0]       taps,
                                          input logic [AO_W-1:0]   strength);
    logic       a;
    logic       b;
    logic       c;
    logic [1:0] n;
    logic [8:0] prod;
    a = mask[taps[14:10]];
    b = mask[taps[9:5]];
    c = mask[taps[4:0]];
    n = (a && b) ? 2'd3 : (2'(a) + 2'(b) + 2'(c));
    prod = 9'(n) * 9'(strength);
    return (prod > 9'd255) ? 8'd255 : prod[7:0];
  endfunction

endpackage

/* hdl/vfao_front.sv */
// ----------------------------------------------------------------------------
// vfao_front
// Takes voxel items, clamps coordinates, finds open faces, drops voxels
// that emit nothing and pushes the rest toward the face queue.
// ----------------------------------------------------------------------------
module vfao_front #(
  parameter int CHUNK_EDGE = vfao_pkg::CHUNK_EDGE_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            vox_valid,
  output logic            vox_ready,
  input  vfao_pkg::in_t   vox,
  output logic            push_valid,
  input  logic            push_ready,
  output vfao_pkg::entry_t push_entry
);
  import vfao_pkg::*;

  localparam logic [3:0] EdgeMax = 4'(CHUNK_EDGE - 1);

  function automatic logic [3:0] clamp(input logic [3:0] c);
    return (int'(c) >= CHUNK_EDGE) ? EdgeMax : c;
  endfunction

  logic [NUM_FACES-1:0] open_faces;
  logic                 keep;

  always_comb begin
    open_faces[FACE_UP] = !vox.neighbour_solid[BIT_UP];
    open_faces[FACE_DN] = !vox.neighbour_solid[BIT_DN];
    open_faces[FACE_NZ] = !vox.neighbour_solid[BIT_NZ];
    open_faces[FACE_PZ] = !vox.neighbour_solid[BIT_PZ];
    open_faces[FACE_PX] = !vox.neighbour_solid[BIT_PX];
    open_faces[FACE_NX] = !vox.neighbour_solid[BIT_NX];
    keep = (vox.block_id != 8'd0) && (open_faces != '0);
  end

  assign vox_ready  = push_ready;
  assign push_valid = vox_valid && keep;

  always_comb begin
    push_entry.x          = clamp(vox.pos_x);
    push_entry.y          = clamp(vox.pos_y);
    push_entry.z          = clamp(vox.pos_z);
    push_entry.id         = vox.block_id;
    push_entry.mask       = vox.neighbour_solid;
    push_entry.open_faces = open_faces;
  end

`ifndef SYNTHESIS
  a_push_has_face: assert property (@(posedge clk) disable iff (rst)
    push_valid |-> (push_entry.open_faces != '0) && (push_entry.id != 8'd0))
    else $error("pushed item with no face");
  a_push_only_on_accept: assert property (@(posedge clk) disable iff (rst)
    (push_valid && push_ready) |-> (vox_valid && vox_ready))
    else $error("push without accepted item");
  a_clamped: assert property (@(posedge clk) disable iff (rst)
    push_valid |-> (int'(push_entry.x) < CHUNK_EDGE) && (int'(push_entry.y) < CHUNK_EDGE)
                   && (int'(push_entry.z) < CHUNK_EDGE))
    else $error("coordinate outside chunk");
`endif

endmodule

/* hdl/vfao_fifo.sv */
// ----------------------------------------------------------------------------
// vfao_fifo
// Short register queue between the front and the back end.
// ----------------------------------------------------------------------------
module vfao_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = vfao_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CntW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(DEPTH))
    else $error("queue count out of range");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (wr_ptr == rd_ptr))
    else $error("empty queue with pointer gap");
  a_grow: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count lost a push");
`endif

endmodule

/* hdl/vfao_back.sv */
// ----------------------------------------------------------------------------
// vfao_back
// Walks the open faces of one voxel, one face a cycle unless stalled, computes
// the vertex occlusion and quad flip, holds each face in an output register.
// ----------------------------------------------------------------------------
module vfao_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [vfao_pkg::AO_W-1:0]   shade_step,
  input  logic                        q_valid,
  output logic                        q_ready,
  input  vfao_pkg::entry_t            q_entry,
  output logic                        face_valid,
  input  logic                        face_ready,
  output vfao_pkg::out_t              face_item
);
  import vfao_pkg::*;

  entry_t               cur;
  logic [NUM_FACES-1:0] rem;
  logic [NUM_FACES-1:0] pick;
  logic [NUM_FACES-1:0] rem_left;
  logic [2:0]           face_idx;
  logic                 busy;
  logic                 advance;
  out_t                 res;
  logic [8:0]           sum_a;
  logic [8:0]           sum_b;

  always_comb begin
    face_idx = '0;
    for (int i = NUM_FACES - 1; i >= 0; i--) begin
      if (rem[i]) begin
        face_idx = 3'(i);
      end
    end
  end

  always_comb begin
    busy     = (rem != '0);
    pick     = rem & (~rem + 1'b1);
    rem_left = rem & ~pick;
    advance  = busy && (!face_valid || face_ready);
    q_ready  = !busy || (advance && (rem_left == '0));
  end

  always_comb begin
    res.face      = face_idx;
    res.out_x     = cur.x;
    res.out_y     = cur.y;
    res.out_z     = cur.z;
    res.out_id    = cur.id;
    res.ao_v0     = ao_value(cur.mask, ao_taps(face_idx, 2'd0), shade_step);
    res.ao_v1     = ao_value(cur.mask, ao_taps(face_idx, 2'd1), shade_step);
    res.ao_v2     = ao_value(cur.mask, ao_taps(face_idx, 2'd2), shade_step);
    res.ao_v3     = ao_value(cur.mask, ao_taps(face_idx, 2'd3), shade_step);
    sum_a         = 9'(res.ao_v1) + 9'(res.ao_v3);
    sum_b         = 9'(res.ao_v0) + 9'(res.ao_v2);
    res.flip_quad = (sum_a > sum_b);
    res.last_face = (rem_left == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem        <= '0;
      face_valid <= 1'b0;
    end else begin
      if (q_valid && q_ready) begin
        rem <= q_entry.open_faces;
      end else if (advance) begin
        rem <= rem_left;
      end
      if (advance) begin
        face_valid <= 1'b1;
      end else if (face_ready) begin
        face_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      cur <= q_entry;
    end
    if (advance) begin
      face_item <= res;
    end
  end

`ifndef SYNTHESIS
  a_one_face: assert property (@(posedge clk) disable iff (rst)
    advance |-> $onehot(pick) && (face_idx < 3'(NUM_FACES)))
    else $error("face pick not one-hot");
  a_more_pending: assert property (@(posedge clk) disable iff (rst)
    (face_valid && !face_item.last_face) |-> busy)
    else $error("non-last face with nothing pending");
  a_queue_entry: assert property (@(posedge clk) disable iff (rst)
    q_valid |-> (q_entry.open_faces != '0))
    else $error("queued voxel has no open face");
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !face_valid && !busy)
    else $error("back end active after reset");
`endif

endmodule

/* hdl/voxel_face_ao_mesher.sv */
// ----------------------------------------------------------------------------
// voxel_face_ao_mesher
// Face culling with per-vertex ambient occlusion for one voxel per item.
// ----------------------------------------------------------------------------
//  channel   signals                         dir  meaning
//  vox       vox_valid/vox_ready/vox         in   one voxel and its 3x3x3 mask
//  face      face_valid/face_ready/face_item out  one open face with AO values
//  cfg       cfg_we/cfg_wdata                in   shade step write
//
//  The face walker in the back end takes the open faces of a voxel one at a
//  time; air and enclosed voxels never reach it.
//  Front accepts whenever the 4-entry queue has room; faces leave through a
//  single output register, and a new voxel is loaded as its last face issues.
//  Reset (rst, synchronous) empties queue and output; the shade step resets to 0.
// ----------------------------------------------------------------------------
module voxel_face_ao_mesher #(
  parameter int CHUNK_EDGE  = vfao_pkg::CHUNK_EDGE_DEF,
  parameter int QUEUE_DEPTH = vfao_pkg::QUEUE_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      vox_valid,
  output logic                      vox_ready,
  input  vfao_pkg::in_t             vox,
  output logic                      face_valid,
  input  logic                      face_ready,
  output vfao_pkg::out_t            face_item,
  input  logic                      cfg_we,
  input  logic [vfao_pkg::AO_W-1:0] cfg_wdata
);
  import vfao_pkg::*;

  logic [AO_W-1:0] shade_step;
  logic            push_valid;
  logic            push_ready;
  entry_t          push_entry;
  logic            q_valid;
  logic            q_ready;
  entry_t          q_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      shade_step <= '0;
    end else if (cfg_we) begin
      shade_step <= cfg_wdata;
    end
  end

  vfao_front #(
    .CHUNK_EDGE (CHUNK_EDGE)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .vox_valid  (vox_valid),
    .vox_ready  (vox_ready),
    .vox        (vox),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  vfao_fifo #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_entry),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_entry)
  );

  vfao_back u_back (
    .clk         (clk),
    .rst         (rst),
    .shade_step  (shade_step),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_entry     (q_entry),
    .face_valid  (face_valid),
    .face_ready  (face_ready),
    .face_item   (face_item)
  );

`ifndef SYNTHESIS
  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> (shade_step == $past(cfg_wdata)))
    else $error("shade step write lost");
  a_face_range: assert property (@(posedge clk) disable iff (rst)
    face_valid |-> (face_item.face < 3'(NUM_FACES)))
    else $error("face code out of range");
  a_no_air: assert property (@(posedge clk) disable iff (rst)
    face_valid |-> (face_item.out_id != 8'd0))
    else $error("face emitted for air");
`endif

endmodule
